@@ rtl/mma_pkg.sv @@
package mma_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int AVG_W      = 16;
    localparam int CFG_W      = 5;
    localparam int FRAC_W     = 4;
    localparam int FIELDS     = 3;
    localparam int GROUP_SIZE = 4;

    localparam int IN_TDATA_W  = ((FIELDS * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((FIELDS * AVG_W + 7) / 8) * 8;

    // reciprocal scale covers dividends below 2**22 (window store up to 64 deep)
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = RECIP_SHIFT + 1;

    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(8);

    typedef struct packed {
        logic store_en;
        logic sum1_en;
        logic sum2_en;
        logic mul_en;
    } lane_ctrl_t;

    // floor(2**22 / d)
    function automatic logic [RECIP_W-1:0] recip(input logic [CFG_W-1:0] d);
        logic [RECIP_W-1:0] r;
        case (d)
            5'd1:    r = 23'd4194304;
            5'd2:    r = 23'd2097152;
            5'd3:    r = 23'd1398101;
            5'd4:    r = 23'd1048576;
            5'd5:    r = 23'd838860;
            5'd6:    r = 23'd699050;
            5'd7:    r = 23'd599186;
            5'd8:    r = 23'd524288;
            5'd9:    r = 23'd466033;
            5'd10:   r = 23'd419430;
            5'd11:   r = 23'd381300;
            5'd12:   r = 23'd349525;
            5'd13:   r = 23'd322638;
            5'd14:   r = 23'd299593;
            5'd15:   r = 23'd279620;
            5'd16:   r = 23'd262144;
            5'd17:   r = 23'd246723;
            5'd18:   r = 23'd233016;
            5'd19:   r = 23'd220752;
            5'd20:   r = 23'd209715;
            5'd21:   r = 23'd199728;
            5'd22:   r = 23'd190650;
            5'd23:   r = 23'd182361;
            5'd24:   r = 23'd174762;
            5'd25:   r = 23'd167772;
            5'd26:   r = 23'd161319;
            5'd27:   r = 23'd155344;
            5'd28:   r = 23'd149796;
            5'd29:   r = 23'd144631;
            5'd30:   r = 23'd139810;
            5'd31:   r = 23'd135300;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/mma_lane.sv @@
module mma_lane #(
    parameter int MAX_WINDOW = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  mma_pkg::lane_ctrl_t                  ctrl,
    input  logic [$clog2(MAX_WINDOW)-1:0]        slot,
    input  logic [mma_pkg::CFG_W-1:0]            win_len,
    input  logic [mma_pkg::SAMPLE_W-1:0]         sample,
    output logic [mma_pkg::AVG_W-1:0]            average
);

    localparam int PTR_W  = $clog2(MAX_WINDOW);
    localparam int GROUPS = (MAX_WINDOW + mma_pkg::GROUP_SIZE - 1) / mma_pkg::GROUP_SIZE;
    localparam int PART_W = mma_pkg::SAMPLE_W + $clog2(mma_pkg::GROUP_SIZE);
    localparam int SUM_W  = mma_pkg::SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int DIV_W  = SUM_W + mma_pkg::FRAC_W;
    localparam int PROD_W = DIV_W + mma_pkg::RECIP_W;
    localparam int QD_W   = DIV_W + mma_pkg::CFG_W;

    logic [mma_pkg::SAMPLE_W-1:0] store_reg [MAX_WINDOW];
    logic [PART_W-1:0]            part_reg  [GROUPS];
    logic [PART_W-1:0]            part_next [GROUPS];
    logic [SUM_W-1:0]             sum_reg;
    logic [SUM_W-1:0]             sum_next;
    logic [DIV_W-1:0]             quo_reg;
    logic [DIV_W-1:0]             quo_next;
    logic [DIV_W-1:0]             dividend;
    logic [PROD_W-1:0]            prod;
    logic [QD_W-1:0]              qd;
    logic [DIV_W-1:0]             rem;
    logic [DIV_W-1:0]             quo_fix;

    // sample ring, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < MAX_WINDOW; k++) begin
                store_reg[k] <= '0;
            end
        end else if (ctrl.store_en) begin
            store_reg[slot] <= sample;
        end
    end

    // first tree level: groups of four, masked by window length
    always_comb begin
        for (int g = 0; g < GROUPS; g++) begin
            part_next[g] = '0;
            for (int j = 0; j < mma_pkg::GROUP_SIZE; j++) begin
                if ((g * mma_pkg::GROUP_SIZE + j) < MAX_WINDOW &&
                    (g * mma_pkg::GROUP_SIZE + j) < int'(win_len)) begin
                    part_next[g] = part_next[g] +
                        PART_W'(store_reg[PTR_W'(g * mma_pkg::GROUP_SIZE + j)]);
                end
            end
        end
    end

    // second tree level
    always_comb begin
        sum_next = '0;
        for (int g = 0; g < GROUPS; g++) begin
            sum_next = sum_next + SUM_W'(part_reg[g]);
        end
    end

    // quotient estimate by reciprocal, low by at most one
    assign dividend = {sum_reg, {mma_pkg::FRAC_W{1'b0}}};
    assign prod     = PROD_W'(dividend) * PROD_W'(mma_pkg::recip(win_len));
    assign quo_next = prod[mma_pkg::RECIP_SHIFT +: DIV_W];

    always_ff @(posedge aclk) begin
        if (ctrl.sum1_en) begin
            for (int g = 0; g < GROUPS; g++) begin
                part_reg[g] <= part_next[g];
            end
        end
        if (ctrl.sum2_en) begin
            sum_reg <= sum_next;
        end
        if (ctrl.mul_en) begin
            quo_reg <= quo_next;
        end
    end

    // remainder check fixes the estimate
    assign qd      = QD_W'(quo_reg) * QD_W'(win_len);
    assign rem     = dividend - qd[DIV_W-1:0];
    assign quo_fix = (rem >= DIV_W'(win_len)) ? quo_reg + DIV_W'(1) : quo_reg;
    assign average = quo_fix[mma_pkg::AVG_W-1:0];

endmodule

@@ rtl/multichannel_moving_average.sv @@
// Moving average over a ring of ADC snapshots, one lane per channel. Each accepted item
// (three 12-bit samples) is written into the ring slot under the slot pointer, which wraps
// at the effective window length (window_len, 0 read as 1, capped at MAX_WINDOW). Each
// lane then sums its first window_len slots and divides by window_len, giving an unsigned
// average with 4 fraction bits, rounded down. Between acceptance and the output register,
// the ring is written at the accepting edge, then the item passes the partial-sum and sum
// registers of the adder tree, the reciprocal multiply into the quotient register and the
// remainder correction into the output register. A new item is accepted in the cycle after
// the previous result has moved into the output register, so items do not overlap; that
// move waits while m_tvalid is high and m_tready is low.
// The ring is cleared by reset itself, so the first averages ramp up from zero.
module multichannel_moving_average #(
    parameter int CHANNELS   = 3,
    parameter int MAX_WINDOW = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mma_pkg::CFG_W-1:0]           cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // sample_a, sample_b, sample_c, zero fill
    input  logic [mma_pkg::IN_TDATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // average_a, average_b, average_c
    output logic [mma_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    localparam int PTR_W     = $clog2(MAX_WINDOW);
    localparam int CMP_W     = ((PTR_W > mma_pkg::CFG_W) ? PTR_W : mma_pkg::CFG_W) + 1;
    localparam int NUM_LANES = (CHANNELS < mma_pkg::FIELDS) ? CHANNELS : mma_pkg::FIELDS;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM1 = 3'd1;
    localparam logic [2:0] ST_SUM2 = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]                         state_reg;
    logic [2:0]                         state_next;
    logic [mma_pkg::CFG_W-1:0]          window_len_reg;
    logic [PTR_W-1:0]                   slot_ptr_reg;
    logic [PTR_W-1:0]                   slot_ptr_next;
    logic [mma_pkg::CFG_W-1:0]          eff_len;
    logic [PTR_W-1:0]                   slot_sel;
    logic [CMP_W-1:0]                   slot_inc;
    logic                               accept;
    logic                               load;
    mma_pkg::lane_ctrl_t                ctrl;
    logic [mma_pkg::AVG_W-1:0]          avg [mma_pkg::FIELDS];
    logic [mma_pkg::OUT_TDATA_W-1:0]    m_tdata_reg;
    logic [mma_pkg::OUT_TDATA_W-1:0]    m_tdata_next;
    logic                               m_tvalid_reg;
    logic                               m_tvalid_next;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign load      = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    always_comb begin
        if (window_len_reg == '0) begin
            eff_len = mma_pkg::CFG_W'(1);
        end else if (int'(window_len_reg) > MAX_WINDOW) begin
            eff_len = mma_pkg::CFG_W'(MAX_WINDOW);
        end else begin
            eff_len = window_len_reg;
        end
    end

    // pointer past a shrunken window restarts at slot zero
    assign slot_sel = (CMP_W'(slot_ptr_reg) >= CMP_W'(eff_len)) ? '0 : slot_ptr_reg;
    assign slot_inc = CMP_W'(slot_sel) + CMP_W'(1);
    assign slot_ptr_next = (slot_inc >= CMP_W'(eff_len)) ? '0 : slot_inc[PTR_W-1:0];

    always_comb begin
        state_next    = state_reg;
        ctrl.store_en = 1'b0;
        ctrl.sum1_en  = 1'b0;
        ctrl.sum2_en  = 1'b0;
        ctrl.mul_en   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ctrl.store_en = 1'b1;
                    state_next    = ST_SUM1;
                end
            end
            ST_SUM1: begin
                ctrl.sum1_en = 1'b1;
                state_next   = ST_SUM2;
            end
            ST_SUM2: begin
                ctrl.sum2_en = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            window_len_reg <= mma_pkg::WINDOW_RESET;
            slot_ptr_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                window_len_reg <= cfg_data;
            end
            if (accept) begin
                slot_ptr_reg <= slot_ptr_next;
            end
        end
    end

    // one lane per channel that has an input field
    for (genvar c = 0; c < mma_pkg::FIELDS; c++) begin : g_lane
        if (c < NUM_LANES) begin : g_on
            mma_lane #(
                .MAX_WINDOW (MAX_WINDOW)
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (ctrl),
                .slot    (slot_sel),
                .win_len (eff_len),
                .sample  (s_tdata[c*mma_pkg::SAMPLE_W +: mma_pkg::SAMPLE_W]),
                .average (avg[c])
            );
        end else begin : g_off
            assign avg[c] = '0;
        end
    end

    // merge lane averages into one item
    always_comb begin
        m_tdata_next = '0;
        for (int c = 0; c < mma_pkg::FIELDS; c++) begin
            m_tdata_next[c*mma_pkg::AVG_W +: mma_pkg::AVG_W] = avg[c];
        end
    end

    always_comb begin
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (CMP_W'(slot_ptr_reg) < CMP_W'($past(eff_len))))
        else $error("slot pointer left the window");

    a_load_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside done state");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid_reg && !m_tready) |=> (state_reg == ST_DONE))
        else $error("finished item dropped while output stalled");

endmodule
